// File: sv/occupancy_presence_monitor_macros.svh
// Assertion helpers for the presence monitor; all checks run on clk_i and
// are switched off while rst_ni is low.
`ifndef OCCUPANCY_PRESENCE_MONITOR_MACROS_SVH
`define OCCUPANCY_PRESENCE_MONITOR_MACROS_SVH

// Same-cycle implication.
`define OPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("occupancy_presence_monitor: check failed");

// Implication checked in the next cycle.
`define OPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("occupancy_presence_monitor: check failed");

`endif

// File: sv/opm_pkg.sv
package opm_pkg;

  localparam int unsigned ForceW  = 12;
  localparam int unsigned WidthW  = 16;
  localparam int unsigned WindowW = 8;
  localparam int unsigned IdleW   = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ForceW-1:0]  ForceThreshReset  = 12'd819;
  localparam logic [WidthW-1:0]  MotionThreshReset = 16'd48;
  localparam logic [WindowW-1:0] WindowTicksReset  = 8'd3;
  localparam logic [IdleW-1:0]   IdleTimeoutReset  = 16'd600;

  typedef enum logic [1:0] {
    MSG_NONE  = 2'd0,
    MSG_WAKE  = 2'd1,
    MSG_SLEEP = 2'd2
  } msg_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FORCE_THRESHOLD    = 2'd0,
    CFG_MOTION_THRESHOLD   = 2'd1,
    CFG_WINDOW_TICKS       = 2'd2,
    CFG_IDLE_TIMEOUT_TICKS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              action;
    logic              echo_seen;
    logic [WidthW-1:0] rise_time;
    logic [WidthW-1:0] fall_time;
    logic [ForceW-1:0] force_sample;
    logic              pir_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        message;
    logic              present_now;
    logic [WidthW-1:0] motion_level;
    logic [WidthW-1:0] pulse_width;
  } out_item_t;

  typedef struct packed {
    logic [ForceW-1:0]  force_threshold;
    logic [WidthW-1:0]  motion_threshold;
    logic [WindowW-1:0] window_ticks;
    logic [IdleW-1:0]   idle_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic monitoring;
    logic wake_sent;
    logic sleep_sent;
  } core_status_t;

endpackage

// File: sv/opm_in_if.sv
interface opm_in_if;
  logic             valid;
  logic             ready;
  opm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/opm_out_if.sv
interface opm_out_if;
  logic              valid;
  logic              ready;
  opm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/opm_cfg_regs.sv
module opm_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [opm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [opm_pkg::CfgW-1:0]     cfg_wdata_i,
  output opm_pkg::cfg_t                cfg_o
);

  opm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_threshold    <= opm_pkg::ForceThreshReset;
      cfg_q.motion_threshold   <= opm_pkg::MotionThreshReset;
      cfg_q.window_ticks       <= opm_pkg::WindowTicksReset;
      cfg_q.idle_timeout_ticks <= opm_pkg::IdleTimeoutReset;
    end else if (cfg_we_i) begin
      unique case (opm_pkg::cfg_reg_e'(cfg_idx_i))
        opm_pkg::CFG_FORCE_THRESHOLD: begin
          cfg_q.force_threshold <= cfg_wdata_i[opm_pkg::ForceW-1:0];
        end
        opm_pkg::CFG_MOTION_THRESHOLD: begin
          cfg_q.motion_threshold <= cfg_wdata_i[opm_pkg::WidthW-1:0];
        end
        opm_pkg::CFG_WINDOW_TICKS: begin
          cfg_q.window_ticks <= cfg_wdata_i[opm_pkg::WindowW-1:0];
        end
        opm_pkg::CFG_IDLE_TIMEOUT_TICKS: begin
          cfg_q.idle_timeout_ticks <= cfg_wdata_i[opm_pkg::IdleW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/opm_in_stage.sv
module opm_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  opm_in_if.sink     in_i,
  opm_in_if.source   s1_o
);

  logic              valid_q;
  opm_pkg::in_item_t data_q;

  // Take a new word whenever the register is empty or drains this cycle.
  assign in_i.ready = !valid_q || s1_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q <= in_i.data;
    end
  end

  assign s1_o.valid = valid_q;
  assign s1_o.data  = data_q;

endmodule

// File: sv/opm_core.sv
module opm_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  opm_pkg::cfg_t         cfg_i,
  opm_in_if.sink                s1_i,
  opm_out_if.source             res_o,
  output opm_pkg::core_status_t status_o
);

  logic                          monitoring_q, monitoring_d;
  logic [opm_pkg::WidthW-1:0]    curr_width_q, curr_width_d;
  logic [opm_pkg::WidthW-1:0]    prev_width_q, prev_width_d;
  logic [opm_pkg::WidthW-1:0]    motion_held_q, motion_held_d;
  logic [opm_pkg::WindowW-1:0]   window_count_q, window_count_d;
  logic                          presence_seen_q, presence_seen_d;
  logic [opm_pkg::IdleW-1:0]     idle_count_q, idle_count_d;
  logic                          wake_sent_q, wake_sent_d;
  logic                          sleep_sent_q, sleep_sent_d;

  logic                          take;
  logic                          rise_gt_fall;
  logic [opm_pkg::WidthW-1:0]    echo_width;
  logic [opm_pkg::WindowW-1:0]   window_inc;
  logic                          present;
  opm_pkg::msg_e                 msg;

  assign take = s1_i.valid && res_o.ready;

  assign rise_gt_fall = s1_i.data.rise_time > s1_i.data.fall_time;
  // A wrapped capture loses one count against plain subtraction.
  assign echo_width = s1_i.data.fall_time - s1_i.data.rise_time
                    - {{(opm_pkg::WidthW-1){1'b0}}, rise_gt_fall};
  assign window_inc = window_count_q + {{(opm_pkg::WindowW-1){1'b0}}, 1'b1};

  always_comb begin
    monitoring_d    = monitoring_q;
    curr_width_d    = curr_width_q;
    prev_width_d    = prev_width_q;
    motion_held_d   = motion_held_q;
    window_count_d  = window_count_q;
    presence_seen_d = presence_seen_q;
    idle_count_d    = idle_count_q;
    wake_sent_d     = wake_sent_q;
    sleep_sent_d    = sleep_sent_q;
    msg             = opm_pkg::MSG_NONE;
    present         = 1'b0;

    if (s1_i.data.action) begin
      msg          = opm_pkg::MSG_SLEEP;
      monitoring_d = 1'b1;
    end else if (monitoring_q) begin
      if (s1_i.data.echo_seen) begin
        // Equal captures hold the previous width.
        if (s1_i.data.rise_time != s1_i.data.fall_time) begin
          curr_width_d = echo_width;
        end
        motion_held_d = (prev_width_q > curr_width_d) ? (prev_width_q - curr_width_d)
                                                      : (curr_width_d - prev_width_q);
        prev_width_d  = curr_width_d;
      end

      present = (s1_i.data.force_sample > cfg_i.force_threshold) &&
                (s1_i.data.pir_level || (motion_held_d > cfg_i.motion_threshold));

      presence_seen_d = presence_seen_q || present;
      idle_count_d    = idle_count_q + {{(opm_pkg::IdleW-1){1'b0}}, 1'b1};
      window_count_d  = window_inc;

      if (window_inc == cfg_i.window_ticks) begin
        if (presence_seen_d) begin
          if (!wake_sent_q) begin
            wake_sent_d = 1'b1;
            msg         = opm_pkg::MSG_WAKE;
          end
          idle_count_d    = '0;
          presence_seen_d = 1'b0;
          sleep_sent_d    = 1'b0;
        end
        window_count_d = '0;
      end

      // Sleep overrides a wake on the same tick.
      if ((idle_count_d >= cfg_i.idle_timeout_ticks) && !sleep_sent_d) begin
        msg          = opm_pkg::MSG_SLEEP;
        idle_count_d = '0;
        sleep_sent_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      monitoring_q    <= 1'b0;
      curr_width_q    <= '0;
      prev_width_q    <= '0;
      motion_held_q   <= '0;
      window_count_q  <= '0;
      presence_seen_q <= 1'b0;
      idle_count_q    <= '0;
      wake_sent_q     <= 1'b0;
      sleep_sent_q    <= 1'b0;
    end else if (take) begin
      monitoring_q    <= monitoring_d;
      curr_width_q    <= curr_width_d;
      prev_width_q    <= prev_width_d;
      motion_held_q   <= motion_held_d;
      window_count_q  <= window_count_d;
      presence_seen_q <= presence_seen_d;
      idle_count_q    <= idle_count_d;
      wake_sent_q     <= wake_sent_d;
      sleep_sent_q    <= sleep_sent_d;
    end
  end

  assign s1_i.ready             = res_o.ready;
  assign res_o.valid            = s1_i.valid;
  assign res_o.data.message     = msg;
  assign res_o.data.present_now = present;
  assign res_o.data.motion_level = motion_held_d;
  assign res_o.data.pulse_width  = curr_width_d;

  assign status_o.monitoring = monitoring_q;
  assign status_o.wake_sent  = wake_sent_q;
  assign status_o.sleep_sent = sleep_sent_q;

endmodule

// File: sv/opm_out_stage.sv
module opm_out_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  opm_out_if.sink     res_i,
  opm_out_if.source   out_o
);

  logic               valid_q;
  opm_pkg::out_item_t data_q;

  // Load whenever empty or the current word leaves this cycle.
  assign res_i.ready = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.ready) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.ready && res_i.valid) begin
      data_q <= res_i.data;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

endmodule

// File: sv/occupancy_presence_monitor.sv
// Occupancy presence monitor: takes one tick or button word per clock cycle
// while the output is not stalled and returns exactly one result word for
// each, via the input register, the core logic, then the result register.
// The sensor fusion, window and idle counters are combinational in the core
// and register as each word is taken; a stalled output holds the words in
// flight and stops in_i once the input register is full. Configuration writes
// are taken at any edge with cfg_we_i high and should be made while no word is in flight.
`include "occupancy_presence_monitor_macros.svh"

module occupancy_presence_monitor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [opm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [opm_pkg::CfgW-1:0]    cfg_wdata_i,
  opm_in_if.sink                      in_i,
  opm_out_if.source                   out_o
);

  opm_pkg::cfg_t         cfg;
  opm_pkg::core_status_t status;

  opm_in_if  s1_if ();
  opm_out_if res_if ();

  opm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  opm_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .s1_o   (s1_if)
  );

  opm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .s1_i     (s1_if),
    .res_o    (res_if),
    .status_o (status)
  );

  opm_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res_if),
    .out_o  (out_o)
  );

  logic core_take;
  logic core_wake;

  assign core_take = res_if.valid && res_if.ready;
  assign core_wake = core_take && (res_if.data.message == opm_pkg::MSG_WAKE);

  `OPM_ASSERT_NOW(a_ready_when_out_free, (!out_o.valid || out_o.ready), in_i.ready)
  `OPM_ASSERT_NEXT(a_s1_held_on_stall, (s1_if.valid && out_o.valid && !out_o.ready), s1_if.valid)
  `OPM_ASSERT_NEXT(a_wake_sets_flag, core_wake, status.wake_sent)
  `OPM_ASSERT_NOW(a_wake_only_once, status.wake_sent, !core_wake)
  `OPM_ASSERT_NOW(a_no_presence_driving, (core_take && !status.monitoring), !res_if.data.present_now)

endmodule
